// ===== src/bpc_pkg.sv =====
package bpc_pkg;

  localparam int DivW = 32;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_CAL_A = 2'd0,
    REG_CAL_B = 2'd1,
    REG_CAL_C = 2'd2,
    REG_OSS   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } coef_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    asr = 32'($signed(v) >>> n);
  endfunction

endpackage

// ===== src/bpc_udiv.sv =====
module bpc_udiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        out_valid,
  output logic [31:0] quo
);
  import bpc_pkg::*;

  logic [DivW-1:0] q_st [DivW+1];
  logic [DivW-1:0] r_st [DivW+1];
  logic [DivW-1:0] d_st [DivW+1];
  logic            v_st [DivW+1];

  always_comb begin
    q_st[0] = num;
    r_st[0] = '0;
    d_st[0] = den;
    v_st[0] = in_valid;
  end

  for (genvar i = 0; i < DivW; i++) begin : g_st
    logic [DivW:0] rs;
    logic [DivW:0] df;
    assign rs = {r_st[i], q_st[i][DivW-1]};
    assign df = rs - {1'b0, d_st[i]};
    always_ff @(posedge clk) begin
      v_st[i+1] <= rst ? 1'b0 : v_st[i];
      d_st[i+1] <= d_st[i];
      if (!df[DivW]) begin
        r_st[i+1] <= df[DivW-1:0];
        q_st[i+1] <= {q_st[i][DivW-2:0], 1'b1};
      end else begin
        r_st[i+1] <= rs[DivW-1:0];
        q_st[i+1] <= {q_st[i][DivW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_st[DivW];
  assign quo = q_st[DivW];
endmodule

// ===== src/bpc_delay.sv =====
module bpc_delay (
  input  logic          clk,
  input  logic [191:0]  d,
  output logic [191:0]  q
);
  import bpc_pkg::*;

  logic [191:0] line [DivW];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < DivW; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[DivW-1];
endmodule

// ===== src/barometric_pressure_compensation.sv =====
// Barometric pressure compensation, integer datasheet algorithm.
// Input: start with in_item (raw temperature and raw pressure); busy is
// always low, so one transaction may start every clock cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Write only while no transaction is in flight.
// Output: done strobes for one cycle with result; the receiver cannot stall.
// Two 32-stage restoring dividers (the temperature divide and the pressure
// divide) dominate the pipeline, plus multiply stages around them.
// Throughput is one transaction per cycle.
// Division by zero gives zero results and divide_error set.
// Reset clears the pipeline valid bits and the configuration registers to zero.
module barometric_pressure_compensation (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bpc_pkg::in_item_t   in_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                done,
  output bpc_pkg::out_item_t  result
);
  import bpc_pkg::*;

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss;
  coef_t       k;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
      oss <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_CAL_A: cal_a <= cfg_data;
        REG_CAL_B: cal_b <= cfg_data;
        REG_CAL_C: cal_c <= cfg_data[31:0];
        REG_OSS:   oss <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    k.ac1 = sx16(cal_a[15:0]);
    k.ac2 = sx16(cal_a[31:16]);
    k.ac3 = sx16(cal_a[47:32]);
    k.ac4 = {16'd0, cal_a[63:48]};
    k.ac5 = {16'd0, cal_b[15:0]};
    k.ac6 = {16'd0, cal_b[31:16]};
    k.b1  = sx16(cal_b[47:32]);
    k.b2  = sx16(cal_b[63:48]);
    k.mc  = sx16(cal_c[15:0]);
    k.md  = sx16(cal_c[31:16]);
    k.oss = oss;
  end

  // s1: x1 product
  logic        v1;
  logic [31:0] p1, up1;
  always_ff @(posedge clk) begin
    v1 <= rst ? 1'b0 : start;
    p1 <= ({16'd0, in_item.raw_temperature} - k.ac6) * k.ac5;
    up1 <= 32'({8'd0, in_item.raw_pressure} >> (4'd8 - {2'b0, k.oss}));
  end

  // s2: x1, den, signed magnitudes
  logic        v2, ng2, dz2;
  logic [31:0] x1_2, up2, nm2, dm2;
  always_ff @(posedge clk) begin
    logic [31:0] x1, den, num;
    x1 = asr(p1, 5'd15);
    den = x1 + k.md;
    num = k.mc << 11;
    v2 <= rst ? 1'b0 : v1;
    x1_2 <= x1;
    up2 <= up1;
    dz2 <= (den == 0);
    ng2 <= num[31] ^ den[31];
    nm2 <= num[31] ? -num : num;
    dm2 <= den[31] ? -den : den;
  end

  logic        vd1;
  logic [31:0] q1;
  logic [191:0] dl1_in, dl1_out;
  bpc_udiv u_div_t (.clk, .rst, .in_valid(v2), .num(nm2), .den(dm2 | {31'd0, dz2}),
                    .out_valid(vd1), .quo(q1));
  assign dl1_in = {96'd0, x1_2, up2, {30'd0, ng2, dz2}};
  bpc_delay u_dl1 (.clk, .d(dl1_in), .q(dl1_out));

  // s3: b5, b6, temp
  logic        v3, dz3;
  logic [31:0] b5_3, b6_3, up3, t3;
  always_ff @(posedge clk) begin
    logic [31:0] x2, b5;
    x2 = dl1_out[1] ? -q1 : q1;
    b5 = dl1_out[95:64] + x2;
    v3 <= rst ? 1'b0 : vd1;
    dz3 <= dl1_out[0];
    b5_3 <= b5;
    b6_3 <= b5 - 32'd4000;
    t3 <= asr(b5 + 32'd8, 5'd4);
    up3 <= dl1_out[63:32];
  end

  // s4: products on b6
  logic        v4, dz4;
  logic [31:0] sq4, ac2b6, ac3b6, up4, t4;
  always_ff @(posedge clk) begin
    v4 <= rst ? 1'b0 : v3;
    dz4 <= dz3;
    sq4 <= asr(b6_3 * b6_3, 5'd12);
    ac2b6 <= asr(k.ac2 * b6_3, 5'd11);
    ac3b6 <= asr(k.ac3 * b6_3, 5'd13);
    up4 <= up3;
    t4 <= t3;
  end

  // s5: products on sq
  logic        v5, dz5;
  logic [31:0] b3_5, x3_5, up5, t5;
  always_ff @(posedge clk) begin
    logic [31:0] x1, x2;
    x1 = asr(k.b2 * sq4, 5'd11);
    x2 = asr(k.b1 * sq4, 5'd16);
    v5 <= rst ? 1'b0 : v4;
    dz5 <= dz4;
    b3_5 <= asr(((k.ac1 * 32'd4 + x1 + ac2b6) << k.oss) + 32'd2, 5'd2);
    x3_5 <= asr(ac3b6 + x2 + 32'd2, 5'd2);
    up5 <= up4;
    t5 <= t4;
  end

  // s6: b4, b7
  logic        v6, dz6;
  logic [31:0] b4_6, b7_6, t6;
  always_ff @(posedge clk) begin
    logic [31:0] b4;
    b4 = (k.ac4 * (x3_5 + 32'd32768)) >> 15;
    v6 <= rst ? 1'b0 : v5;
    dz6 <= dz5 | (b4 == 0);
    b4_6 <= b4;
    b7_6 <= (up5 - b3_5) * (32'd50000 >> k.oss);
    t6 <= t5;
  end

  logic        vd2, big;
  logic [31:0] q2;
  logic [191:0] dl2_in, dl2_out;
  bpc_udiv u_div_p (.clk, .rst, .in_valid(v6),
                    .num(b7_6[31] ? b7_6 : (b7_6 << 1)),
                    .den(b4_6 | {31'd0, dz6}), .out_valid(vd2), .quo(q2));
  assign dl2_in = {128'd0, t6, {30'd0, b7_6[31], dz6}};
  bpc_delay u_dl2 (.clk, .d(dl2_in), .q(dl2_out));
  assign big = dl2_out[1];

  // s7: p and correction products
  logic        v7, dz7;
  logic [31:0] p7, x1_7, x2_7, t7;
  always_ff @(posedge clk) begin
    logic [31:0] p, ps;
    p = big ? (q2 << 1) : q2;
    ps = asr(p, 5'd8);
    v7 <= rst ? 1'b0 : vd2;
    dz7 <= dl2_out[0];
    p7 <= p;
    x1_7 <= ps * ps;
    x2_7 <= asr(32'd0 - (32'd7357 * p), 5'd16);
    t7 <= dl2_out[63:32];
  end

  // s8: final
  always_ff @(posedge clk) begin
    logic [31:0] x1;
    x1 = asr(x1_7 * 32'd3038, 5'd16);
    done <= rst ? 1'b0 : v7;
    result.divide_error <= dz7;
    result.temperature_tenths <= dz7 ? '0 : $signed(t7);
    result.pressure_pa <= dz7 ? '0 :
                          $signed(p7 + asr(x1 + x2_7 + 32'd3791, 5'd4));
  end
endmodule

// ===== dv/tb_barometric_pressure_compensation.sv =====
`timescale 1ns / 100ps

module tb_barometric_pressure_compensation;
  import bpc_pkg::*;

  localparam int LATENCY = 80;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t in_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;
  logic done;
  out_item_t result;

  logic [63:0] cal_a, cal_b, cal_c;
  logic [1:0] oss_q;
  out_item_t expected_q[$];
  int mismatches;
  int checked;
  int idle_cycles;
  int div_errors;

  barometric_pressure_compensation DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sra(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic out_item_t compensate(input in_item_t it);
    out_item_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, b3, b4, b7, p, sq, t;
    logic signed [63:0] qn, qd;
    ac1 = {{16{cal_a[15]}}, cal_a[15:0]};
    ac2 = {{16{cal_a[31]}}, cal_a[31:16]};
    ac3 = {{16{cal_a[47]}}, cal_a[47:32]};
    ac4 = {16'd0, cal_a[63:48]};
    ac5 = {16'd0, cal_b[15:0]};
    ac6 = {16'd0, cal_b[31:16]};
    b1 = {{16{cal_b[47]}}, cal_b[47:32]};
    b2 = {{16{cal_b[63]}}, cal_b[63:48]};
    mc = {{16{cal_c[15]}}, cal_c[15:0]};
    md = {{16{cal_c[31]}}, cal_c[31:16]};
    ut = {16'd0, it.raw_temperature};
    up = {8'd0, it.raw_pressure} >> (8 - oss_q);
    r = '0;
    r.divide_error = 1'b1;
    x1 = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    qn = $signed(mc << 11);
    qd = $signed(den);
    x2 = 32'(qn / qd);
    b5 = x1 + x2;
    t = sra(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (32'd50000 >> oss_q);
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra(32'd0 - (32'd7357 * p), 16);
    p = p + sra(x1 + x2 + 32'd3791, 4);
    r.temperature_tenths = t;
    r.pressure_pa = p;
    r.divide_error = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: actual %h", $time, result);
          mismatches++;
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          checked++;
          if (e.divide_error) div_errors++;
          if (result.temperature_tenths !== e.temperature_tenths) begin
            $display("%0t temperature_tenths: expected %0d actual %0d", $time,
                     e.temperature_tenths, result.temperature_tenths);
            mismatches++;
          end
          if (result.pressure_pa !== e.pressure_pa) begin
            $display("%0t pressure_pa: expected %0d actual %0d", $time,
                     e.pressure_pa, result.pressure_pa);
            mismatches++;
          end
          if (result.divide_error !== e.divide_error) begin
            $display("%0t divide_error: expected %0b actual %0b", $time,
                     e.divide_error, result.divide_error);
            mismatches++;
          end
        end
      end
    end
  end

  int burst_left;

  task automatic send_item(input logic [15:0] ut, input logic [23:0] up);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_item <= '{raw_temperature: ut, raw_pressure: up};
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(compensate('{raw_temperature: ut, raw_pressure: up}));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAL_A: cal_a = val;
      REG_CAL_B: cal_b = val;
      REG_CAL_C: cal_c = {32'd0, val[31:0]};
      REG_OSS: oss_q = val[1:0];
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [63:0] a, input logic [63:0] b,
                          input logic [31:0] c, input logic [1:0] o);
    write_reg(REG_CAL_A, a);
    write_reg(REG_CAL_B, b);
    write_reg(REG_CAL_C, {32'd0, c});
    write_reg(REG_OSS, {62'd0, o});
  endtask

  // datasheet sample coefficients
  localparam logic [63:0] NOM_A = {16'd34171, 16'hFFFF & -16'sd14383,
                                   16'hFFFF & -16'sd72, 16'd408};
  localparam logic [63:0] NOM_B = {16'd4, 16'd6190, 16'd23153, 16'd32757};
  localparam logic [31:0] NOM_C = {16'd2868, 16'hFFFF & -16'sd8711};

  task automatic test_reset_defaults();
    send_item(16'd27898, 24'd0);
    send_item(16'hFFFF, 24'hFFFFFF);
    drain();
  endtask

  task automatic test_directed();
    for (int o = 0; o < 4; o++) begin
      load_cal(NOM_A, NOM_B, NOM_C, 2'(o));
      send_item(16'd27898, 24'd23843 << (8 - o));
      send_item(16'd0, 24'd0);
      send_item(16'hFFFF, 24'hFFFFFF);
      send_item(16'h8000, 24'h800000);
      drain();
    end
    // temperature divisor zero: ac5 = 0 so x1 = 0, md = 0
    load_cal(NOM_A, {NOM_B[63:16], 16'd0}, 32'd0, 2'd0);
    send_item(16'd1234, 24'd5678);
    drain();
    // pressure divisor zero: ac4 = 0
    load_cal({16'd0, NOM_A[47:0]}, NOM_B, NOM_C, 2'd1);
    send_item(16'd27898, 24'h5D2300);
    drain();
    // extreme coefficients
    load_cal('1, '1, '1, 2'd3);
    send_item(16'hFFFF, 24'hFFFFFF);
    send_item(16'd0, 24'd1);
    drain();
    load_cal({16'hFFFF, 16'h8000, 16'h8000, 16'h8000},
             {16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF}, 32'h7FFF_8000, 2'd2);
    send_item(16'h7FFF, 24'hABCDEF);
    send_item(16'd1, 24'h000100);
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 13; phase++) begin
      if (phase % 3 == 2)
        load_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2'($urandom));
      else
        load_cal(NOM_A ^ {16'($urandom_range(0, 255)), 48'($urandom_range(0, 63))},
                 NOM_B ^ {32'($urandom_range(0, 15)), 32'($urandom_range(0, 255))},
                 NOM_C ^ 32'($urandom_range(0, 31)), 2'($urandom));
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 9) < 7)
          send_item(16'($urandom_range(20000, 36000)),
                    24'($urandom_range(15000, 45000) << (8 - oss_q)));
        else
          send_item(16'($urandom), 24'($urandom));
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal_a = '0;
    cal_b = '0;
    cal_c = '0;
    oss_q = '0;
    mismatches = 0;
    checked = 0;
    div_errors = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    $display("checked %0d results (%0d with divide error) over all oversampling settings",
             checked, div_errors);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
